// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the array table engine top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// expression never true
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

// ===== rtl/core/bate_pkg.sv =====
// package with widths, codes and state type of the array table engine
`default_nettype none

package bate_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   // beat field widths
   localparam int OP_W  = 3;
   localparam int POS_W = 7;
   localparam int ST_W  = 2;
   localparam int IDX_W = 6;
   localparam int REQ_W = 48;
   localparam int RSP_W = 16;

   // operation codes
   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OP_W-1:0] OP_SORTED = 3'd4;

   // status codes
   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SHIFT_UP = 6'b000010,
      S_SHIFT_DN = 6'b000100,
      S_SEARCH   = 6'b001000,
      S_SORT     = 6'b010000,
      S_RESP     = 6'b100000
   } bate_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/bounded_array_table_engine.sv =====
// top level of the bounded array table engine
`default_nettype none
`include "assert_macros.svh"

// bounded array table engine
//
// keeps a packed array of up to DEPTH signed 32-bit words in one ram and its
// length in a register. each req beat carries one operation: append, insert
// at a position, delete at a position, search for a value, or sorted insert.
// every operation answers with one rsp beat, except a search, which answers
// with one beat per matching index in ascending order (tlast on the final one)
// or a single not-found beat.
//
// req_tready is high while the sequencer is idle; a finished result may still
// sit in the output register while the next req beat is taken. the ram is read
// and written back one entry per cycle. append, errors and unused codes walk no
// entries; the other operations walk n entries (moved, compared or searched),
// at most DEPTH. a stalled rsp side holds the output register; a search then
// pauses its walk. reset empties the array at once (length cleared, no ram
// sweep).
module bounded_array_table_engine (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // operation[2:0], value[34:3], position[41:35], zero fill above
   input  wire logic [bate_pkg::REQ_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // status[1:0], found_index[7:2], count_now[14:8], zero fill above
   output logic      [bate_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   import bate_pkg::*;

   // request fields
   logic [OP_W-1:0]   req_op;
   logic [DATA_W-1:0] req_val;
   logic [POS_W-1:0]  req_pos;

   assign req_op  = req_tdata[OP_W-1:0];
   assign req_val = req_tdata[OP_W +: DATA_W];
   assign req_pos = req_tdata[OP_W+DATA_W +: POS_W];

   // control state
   bate_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              data_v_ff, data_v_in;
   logic              hit_pend_ff, hit_pend_in;
   logic              out_v_ff, out_v_in;

   // working registers
   logic [DATA_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;      // next read address, or hole index in sort
   logic [ADDR_W-1:0] data_idx_ff, data_idx_in;  // address of the word on the ram read port
   logic [ADDR_W-1:0] hit_idx_ff, hit_idx_in;
   logic [ST_W-1:0]   res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_idx_ff, res_idx_in;

   // output register
   logic [ST_W-1:0]   out_status_ff;
   logic [IDX_W-1:0]  out_idx_ff;
   logic [CNT_W-1:0]  out_cnt_ff;
   logic              out_last_ff;

   // ram port
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   // emit into the output register
   logic              emit;
   logic [ST_W-1:0]   emit_status;
   logic [IDX_W-1:0]  emit_idx;
   logic              emit_last;

   logic accept;
   logic out_free;
   logic full;
   logic hit;
   logic consume;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_v_ff || rsp_tready;
   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign hit        = data_v_ff && (rd_data == val_ff);
   // a search word is used up unless a second hit waits on a blocked output
   assign consume    = data_v_ff && (!(hit && hit_pend_ff) || out_free);

   bate_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      data_v_in     = data_v_ff;
      hit_pend_in   = hit_pend_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      rd_ptr_in     = rd_ptr_ff;
      data_idx_in   = data_idx_ff;
      hit_idx_in    = hit_idx_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      emit          = 1'b0;
      emit_status   = ST_OK;
      emit_idx      = '0;
      emit_last     = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in        = req_val;
               data_v_in     = 1'b0;
               hit_pend_in   = 1'b0;
               res_status_in = ST_OK;
               res_idx_in    = '0;
               state_in      = S_RESP;
               case (req_op)
                  OP_APPEND: begin
                     if (full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_W'(cnt_ff);
                        wr_data = req_val;
                        cnt_in  = cnt_ff + 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     if (full) begin
                        res_status_in = ST_FULL;
                     end else if (req_pos > POS_W'(cnt_ff)) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        pos_in    = CNT_W'(req_pos);
                        rd_ptr_in = cnt_ff;
                        state_in  = S_SHIFT_UP;
                     end
                  end
                  OP_DELETE: begin
                     if (req_pos >= POS_W'(cnt_ff)) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        pos_in    = CNT_W'(req_pos);
                        rd_ptr_in = CNT_W'(req_pos) + 1'b1;
                        state_in  = S_SHIFT_DN;
                     end
                  end
                  OP_SEARCH: begin
                     rd_ptr_in = '0;
                     state_in  = S_SEARCH;
                  end
                  OP_SORTED: begin
                     if (full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        // hole starts at the end, first compare with the top entry
                        rd_ptr_in = cnt_ff;
                        state_in  = S_SORT;
                        if (cnt_ff != '0) begin
                           rd_en       = 1'b1;
                           rd_addr     = ADDR_W'(cnt_ff - 1'b1);
                           data_v_in   = 1'b1;
                           data_idx_in = ADDR_W'(cnt_ff - 1'b1);
                        end
                     end
                  end
                  default: begin
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end

         S_SHIFT_UP: begin
            // walk down from the top, each word moves one place up
            if (data_v_ff) begin
               wr_en   = 1'b1;
               wr_addr = data_idx_ff + 1'b1;
               wr_data = rd_data;
            end
            if (rd_ptr_ff > pos_ff) begin
               rd_en       = 1'b1;
               rd_addr     = ADDR_W'(rd_ptr_ff - 1'b1);
               rd_ptr_in   = rd_ptr_ff - 1'b1;
               data_v_in   = 1'b1;
               data_idx_in = ADDR_W'(rd_ptr_ff - 1'b1);
            end else begin
               data_v_in = 1'b0;
               if (!data_v_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = ADDR_W'(pos_ff);
                  wr_data  = val_ff;
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_RESP;
               end
            end
         end

         S_SHIFT_DN: begin
            // walk up from above the hole, each word moves one place down
            if (data_v_ff) begin
               wr_en   = 1'b1;
               wr_addr = data_idx_ff - 1'b1;
               wr_data = rd_data;
            end
            if (rd_ptr_ff < cnt_ff) begin
               rd_en       = 1'b1;
               rd_addr     = ADDR_W'(rd_ptr_ff);
               rd_ptr_in   = rd_ptr_ff + 1'b1;
               data_v_in   = 1'b1;
               data_idx_in = ADDR_W'(rd_ptr_ff);
            end else begin
               data_v_in = 1'b0;
               if (!data_v_ff) begin
                  cnt_in   = cnt_ff - 1'b1;
                  state_in = S_RESP;
               end
            end
         end

         S_SEARCH: begin
            // one hit is held back so the final one can carry tlast
            if (consume && hit) begin
               if (hit_pend_ff) begin
                  emit        = 1'b1;
                  emit_status = ST_OK;
                  emit_idx    = IDX_W'(hit_idx_ff);
                  emit_last   = 1'b0;
               end
               hit_pend_in = 1'b1;
               hit_idx_in  = data_idx_ff;
            end
            if ((rd_ptr_ff < cnt_ff) && (!data_v_ff || consume)) begin
               rd_en       = 1'b1;
               rd_addr     = ADDR_W'(rd_ptr_ff);
               rd_ptr_in   = rd_ptr_ff + 1'b1;
               data_v_in   = 1'b1;
               data_idx_in = ADDR_W'(rd_ptr_ff);
            end else if (consume) begin
               data_v_in = 1'b0;
            end
            if (!data_v_ff && !(rd_ptr_ff < cnt_ff)) begin
               res_status_in = hit_pend_ff ? ST_OK : ST_NOTFOUND;
               res_idx_in    = hit_pend_ff ? hit_idx_ff : '0;
               state_in      = S_RESP;
            end
         end

         S_SORT: begin
            // rd_ptr_ff is the hole; greater words move up into it
            if (data_v_ff && ($signed(val_ff) < $signed(rd_data))) begin
               wr_en     = 1'b1;
               wr_addr   = ADDR_W'(rd_ptr_ff);
               wr_data   = rd_data;
               rd_ptr_in = rd_ptr_ff - 1'b1;
               if (data_idx_ff != '0) begin
                  rd_en       = 1'b1;
                  rd_addr     = data_idx_ff - 1'b1;
                  data_v_in   = 1'b1;
                  data_idx_in = data_idx_ff - 1'b1;
               end else begin
                  data_v_in = 1'b0;
               end
            end else begin
               wr_en     = 1'b1;
               wr_addr   = ADDR_W'(rd_ptr_ff);
               wr_data   = val_ff;
               data_v_in = 1'b0;
               cnt_in    = cnt_ff + 1'b1;
               state_in  = S_RESP;
            end
         end

         S_RESP: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_status = res_status_ff;
               emit_idx    = IDX_W'(res_idx_ff);
               emit_last   = 1'b1;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_v_in = emit || (out_v_ff && !rsp_tready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         data_v_ff   <= 1'b0;
         hit_pend_ff <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         data_v_ff   <= data_v_in;
         hit_pend_ff <= hit_pend_in;
         out_v_ff    <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      rd_ptr_ff     <= rd_ptr_in;
      data_idx_ff   <= data_idx_in;
      hit_idx_ff    <= hit_idx_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      if (emit) begin
         out_status_ff <= emit_status;
         out_idx_ff    <= emit_idx;
         out_cnt_ff    <= cnt_ff;
         out_last_ff   <= emit_last;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RSP_W'({out_cnt_ff, out_idx_ff, out_status_ff});

   // length never passes the capacity
   `ASSERT_NEVER(a_cnt_bound, cnt_ff > CNT_W'(DEPTH), "element count above capacity")
   // writes stay inside the packed array plus one slot
   `ASSERT_IMPLIES(a_wr_in_range, wr_en, CNT_W'(wr_addr) <= cnt_ff,
      "ram write beyond the array end")
   // an accepted beat always starts work
   `ASSERT_NEXT(a_accept_busy, accept, state_ff != S_IDLE, "accepted beat left idle")
   // a search never changes the length
   `ASSERT_NEXT(a_search_len, state_ff == S_SEARCH, $stable(cnt_ff),
      "length changed during search")

endmodule

`default_nettype wire

// ===== rtl/core/bate_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module bate_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire
